[rtl/loop_load_monitor_top_assert.svh]
// Assertion macros shared by the loop load monitor RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef LOOP_LOAD_MONITOR_TOP_ASSERT_SVH
`define LOOP_LOAD_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication under asynchronous active-low reset.
`define LLM_ASSERT_IMPLY(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under asynchronous active-low reset.
`define LLM_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lmon_pkg.sv]
// Package for the loop load monitor: widths, constants, microcode encoding and program ROM.
// No dependencies; used by lmon_div and loop_load_monitor_top.
package lmon_pkg;

	localparam int QW         = 32;
	localparam int LQW        = 10;
	localparam int PROD_W     = 59;
	localparam int CNT_W      = 6;
	localparam int PC_W       = 4;
	localparam int OP_W       = 3;
	localparam int SRC_W      = 2;
	localparam int COND_W     = 2;
	localparam int INTERVAL_W = 27;
	localparam int KHZ_W      = 20;
	localparam int LOAD_W     = 10;
	localparam int CFG_IDX_W  = 2;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 27'd1000000;
	localparam logic [KHZ_W-1:0]      KHZ_RESET      = 20'd125000;
	localparam logic [INTERVAL_W-1:0] RATE_SCALE     = 27'd1000;
	localparam logic [LOAD_W-1:0]     PERMILLE_FULL  = 10'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KHZ      = 2'd1;

	localparam logic [OP_W-1:0] OP_WAIT  = 3'd0;
	localparam logic [OP_W-1:0] OP_MUL   = 3'd1;
	localparam logic [OP_W-1:0] OP_DIVS  = 3'd2;
	localparam logic [OP_W-1:0] OP_DIVW  = 3'd3;
	localparam logic [OP_W-1:0] OP_PEAK  = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;
	localparam logic [OP_W-1:0] OP_EMIT  = 3'd6;

	localparam logic [SRC_W-1:0] SRC_RATE = 2'd0;
	localparam logic [SRC_W-1:0] SRC_NORM = 2'd1;
	localparam logic [SRC_W-1:0] SRC_LOAD = 2'd2;

	localparam logic [COND_W-1:0] C_NEXT      = 2'd0;
	localparam logic [COND_W-1:0] C_ALWAYS    = 2'd1;
	localparam logic [COND_W-1:0] C_NOT_TAKEN = 2'd2;
	localparam logic [COND_W-1:0] C_PEAK_ZERO = 2'd3;

	localparam logic [PC_W-1:0] ST_WAIT      = 4'd0;
	localparam logic [PC_W-1:0] ST_MUL_RATE  = 4'd1;
	localparam logic [PC_W-1:0] ST_DIVS_RATE = 4'd2;
	localparam logic [PC_W-1:0] ST_DIVW_RATE = 4'd3;
	localparam logic [PC_W-1:0] ST_MUL_NORM  = 4'd4;
	localparam logic [PC_W-1:0] ST_DIVS_NORM = 4'd5;
	localparam logic [PC_W-1:0] ST_DIVW_NORM = 4'd6;
	localparam logic [PC_W-1:0] ST_PEAK      = 4'd7;
	localparam logic [PC_W-1:0] ST_MUL_LOAD  = 4'd8;
	localparam logic [PC_W-1:0] ST_DIVS_LOAD = 4'd9;
	localparam logic [PC_W-1:0] ST_DIVW_LOAD = 4'd10;
	localparam logic [PC_W-1:0] ST_CLEAR     = 4'd11;
	localparam logic [PC_W-1:0] ST_EMIT      = 4'd12;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SRC_W-1:0]  src;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} ctl_word_t;

	typedef struct packed {
		logic start;
		logic short_div;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
	} div_stat_t;

	function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
		ctl_word_t w;
		w = '{op: OP_WAIT, src: SRC_RATE, cond: C_NEXT, target: ST_WAIT};
		unique case (pc)
			ST_WAIT:      w = '{op: OP_WAIT,  src: SRC_RATE, cond: C_NOT_TAKEN, target: ST_EMIT};
			ST_MUL_RATE:  w = '{op: OP_MUL,   src: SRC_RATE, cond: C_NEXT,      target: ST_WAIT};
			ST_DIVS_RATE: w = '{op: OP_DIVS,  src: SRC_RATE, cond: C_NEXT,      target: ST_WAIT};
			ST_DIVW_RATE: w = '{op: OP_DIVW,  src: SRC_RATE, cond: C_NEXT,      target: ST_WAIT};
			ST_MUL_NORM:  w = '{op: OP_MUL,   src: SRC_NORM, cond: C_NEXT,      target: ST_WAIT};
			ST_DIVS_NORM: w = '{op: OP_DIVS,  src: SRC_NORM, cond: C_NEXT,      target: ST_WAIT};
			ST_DIVW_NORM: w = '{op: OP_DIVW,  src: SRC_NORM, cond: C_NEXT,      target: ST_WAIT};
			ST_PEAK:      w = '{op: OP_PEAK,  src: SRC_NORM, cond: C_NEXT,      target: ST_WAIT};
			ST_MUL_LOAD:  w = '{op: OP_MUL,   src: SRC_LOAD, cond: C_PEAK_ZERO, target: ST_CLEAR};
			ST_DIVS_LOAD: w = '{op: OP_DIVS,  src: SRC_LOAD, cond: C_NEXT,      target: ST_WAIT};
			ST_DIVW_LOAD: w = '{op: OP_DIVW,  src: SRC_LOAD, cond: C_NEXT,      target: ST_WAIT};
			ST_CLEAR:     w = '{op: OP_CLEAR, src: SRC_RATE, cond: C_NEXT,      target: ST_WAIT};
			ST_EMIT:      w = '{op: OP_EMIT,  src: SRC_RATE, cond: C_ALWAYS,    target: ST_WAIT};
			default:      w = '{op: OP_WAIT,  src: SRC_RATE, cond: C_ALWAYS,    target: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

[rtl/loop_load_monitor_top.sv]
// Loop load monitor top level: microcoded sequencer, datapath and config registers.
// Depends on lmon_pkg, lmon_div and loop_load_monitor_top_assert.svh.
// A tick that closes no sample goes straight from the wait step to the emit step; one
// that closes a sample runs the shared one-bit-per-cycle divider three times, or
// twice when the peak is zero. One tick is worked on at a time; results leave through an
// output register. Reset is asynchronous and clears state; no clearing pass is needed.
module loop_load_monitor_top #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [31:0]                         now_us,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [31:0]                         iterations_per_sec,
	output logic [lmon_pkg::LOAD_W-1:0]         load_permille,
	output logic                                sample_taken,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lmon_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lmon_pkg::INTERVAL_W-1:0]     cfg_data
);
	import lmon_pkg::*;
	`include "loop_load_monitor_top_assert.svh"

	localparam int DSW = (TIME_WIDTH > QW) ? TIME_WIDTH : QW;

	logic [PC_W-1:0]       pc_q;
	ctl_word_t             cw;
	logic [INTERVAL_W-1:0] interval_q;
	logic [KHZ_W-1:0]      khz_q;
	logic [TIME_WIDTH-1:0] now_m;
	logic [TIME_WIDTH-1:0] elapsed_c;
	logic                  taken_c;
	logic [TIME_WIDTH-1:0] now_q;
	logic [TIME_WIDTH-1:0] elapsed_q;
	logic [TIME_WIDTH-1:0] last_q;
	logic                  taken_q;
	logic [QW-1:0]         tick_q;
	logic [QW-1:0]         rate_q;
	logic [QW-1:0]         permhz_q;
	logic [QW-1:0]         peak_q;
	logic [LOAD_W-1:0]     load_q;
	logic [PROD_W-1:0]     prod_q;
	logic [QW-1:0]         mul_a;
	logic [INTERVAL_W-1:0] mul_b;
	logic [DSW-1:0]        dsr;
	div_ctl_t              div_ctl;
	div_stat_t             div_stat;
	logic [QW-1:0]         quo;
	logic [LOAD_W-1:0]     head;
	logic                  in_acc;
	logic                  out_free;
	logic                  advance;
	logic                  jump;
	logic                  out_valid_q;
	logic [QW-1:0]         out_rate_q;
	logic [LOAD_W-1:0]     out_load_q;
	logic                  out_taken_q;

	assign cw        = ucode_rom(pc_q);
	assign in_stall  = cw.op != OP_WAIT;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign now_m     = TIME_WIDTH'(now_us);
	assign elapsed_c = now_m - last_q;
	assign taken_c   = DSW'(elapsed_c) >= DSW'(interval_q);

	always_comb begin
		unique case (cw.op)
			OP_WAIT: advance = in_acc;
			OP_DIVW: advance = !div_stat.busy;
			OP_EMIT: advance = out_free;
			default: advance = 1'b1;
		endcase
		unique case (cw.cond)
			C_NEXT:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NOT_TAKEN: jump = !taken_c;
			C_PEAK_ZERO: jump = peak_q == '0;
			default:     jump = 1'b0;
		endcase
	end

	always_comb begin
		unique case (cw.src)
			SRC_RATE: begin
				mul_a = tick_q;
				mul_b = interval_q;
				dsr   = DSW'(elapsed_q);
			end
			SRC_NORM: begin
				mul_a = rate_q;
				mul_b = RATE_SCALE;
				dsr   = DSW'(khz_q);
			end
			SRC_LOAD: begin
				mul_a = permhz_q;
				mul_b = RATE_SCALE;
				dsr   = DSW'(peak_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
				dsr   = '0;
			end
		endcase
	end

	assign div_ctl.start     = cw.op == OP_DIVS;
	assign div_ctl.short_div = cw.src == SRC_LOAD;
	assign head              = quo[LOAD_W-1:0];

	lmon_div #(
		.DSW(DSW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (prod_q),
		.divisor  (dsr),
		.stat     (div_stat),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
		end else if (advance) begin
			pc_q <= jump ? cw.target : pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			khz_q      <= KHZ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_INTERVAL) begin
				interval_q <= cfg_data;
			end
			if (cfg_index == REG_KHZ) begin
				khz_q <= cfg_data[KHZ_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q     <= now_m;
			elapsed_q <= elapsed_c;
		end
		if (cw.op == OP_MUL) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q  <= 1'b0;
			tick_q   <= '0;
			last_q   <= '0;
			rate_q   <= '0;
			permhz_q <= '0;
			peak_q   <= '0;
			load_q   <= '0;
		end else begin
			if (in_acc) begin
				taken_q <= taken_c;
				if (tick_q != '1) begin
					tick_q <= tick_q + 1'b1;
				end
			end
			if (cw.op == OP_DIVW && !div_stat.busy) begin
				unique case (cw.src)
					SRC_RATE: rate_q <= (elapsed_q == '0) ? '0 : quo;
					SRC_NORM: begin
						if (khz_q == '0) begin
							permhz_q <= '0;
						end else if (prod_q[PROD_W-1:QW] >= INTERVAL_W'(khz_q)) begin
							permhz_q <= '1;
						end else begin
							permhz_q <= quo;
						end
					end
					SRC_LOAD: load_q <= (head >= PERMILLE_FULL) ? '0 : PERMILLE_FULL - head;
					default: ;
				endcase
			end
			if (cw.op == OP_PEAK && permhz_q > peak_q) begin
				peak_q <= permhz_q;
			end
			if (cw.op == OP_CLEAR) begin
				tick_q <= '0;
				last_q <= now_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_EMIT && out_free) begin
			out_rate_q  <= rate_q;
			out_load_q  <= load_q;
			out_taken_q <= taken_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign iterations_per_sec = out_rate_q;
	assign load_permille      = out_load_q;
	assign sample_taken       = out_taken_q;

	`LLM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, in_stall, "tick accepted twice")
	`LLM_ASSERT_IMPLY(a_div_in_wait, clk, arst_n, div_stat.busy, cw.op == OP_DIVW, "divider runs outside a wait step")
	`LLM_ASSERT_NEXT(a_clear_tick, clk, arst_n, cw.op == OP_CLEAR, tick_q == '0, "tick count not cleared")
	`LLM_ASSERT_IMPLY(a_load_range, clk, arst_n, out_valid_q, out_load_q <= PERMILLE_FULL, "load out of range")

endmodule

[rtl/lmon_div.sv]
// Shared restoring divider of the loop load monitor, one quotient bit per cycle.
// Depends on lmon_pkg for widths and the control and status structs.
module lmon_div #(
	parameter int DSW = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lmon_pkg::div_ctl_t            ctl,
	input  logic [lmon_pkg::PROD_W-1:0]   dividend,
	input  logic [DSW-1:0]                divisor,
	output lmon_pkg::div_stat_t           stat,
	output logic [lmon_pkg::QW-1:0]       quotient
);
	import lmon_pkg::*;

	logic [DSW-1:0]   rem_q;
	logic [DSW-1:0]   dsr_q;
	logic [QW-1:0]    lo_q;
	logic [QW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DSW:0]     trial;
	logic [DSW:0]     diff;
	logic             fits;

	assign trial = {rem_q, lo_q[QW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= ctl.short_div ? CNT_W'(LQW) : CNT_W'(QW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dsr_q <= divisor;
			quo_q <= '0;
			if (ctl.short_div) begin
				rem_q <= DSW'(dividend >> LQW);
				lo_q  <= QW'(dividend[LQW-1:0]) << (QW - LQW);
			end else begin
				rem_q <= DSW'(dividend >> QW);
				lo_q  <= dividend[QW-1:0];
			end
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DSW-1:0] : trial[DSW-1:0];
			lo_q  <= {lo_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign stat.busy = cnt_q != '0;
	assign quotient  = quo_q;

endmodule

[tb/sv/loop_load_monitor_top_tb.sv]
// Self-checking testbench for loop_load_monitor_top: random and directed tick streams
// with random valid/stall idling, checked against a scoreboard that predicts every result.
// Depends on lmon_pkg and the loop_load_monitor_top RTL.
module loop_load_monitor_top_tb;
	import lmon_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [31:0]       ips;
		logic [LOAD_W-1:0] load;
		logic              taken;
	} load_result_t;

	class load_scoreboard;
		logic [INTERVAL_W-1:0] interval;
		logic [KHZ_W-1:0]      khz;
		logic [31:0]           tick_count;
		logic [31:0]           last_stamp;
		logic [31:0]           rate;
		logic [31:0]           peak;
		logic [LOAD_W-1:0]     load;
		load_result_t          expected[$];
		int                    errors;

		function new();
			interval   = INTERVAL_RESET;
			khz        = KHZ_RESET;
			tick_count = '0;
			last_stamp = '0;
			rate       = '0;
			peak       = '0;
			load       = '0;
			errors     = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [INTERVAL_W-1:0] data);
			if (idx == REG_INTERVAL)
				interval = data;
			else if (idx == REG_KHZ)
				khz = data[KHZ_W-1:0];
		endfunction

		function logic [31:0] sat32(input logic [63:0] v);
			return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
		endfunction

		function void note_tick(input logic [31:0] now);
			logic [31:0]  elapsed;
			logic [63:0]  wide;
			logic [63:0]  per_mhz;
			logic [63:0]  headroom;
			load_result_t r;
			elapsed = now - last_stamp;
			r.taken = 1'b0;
			if (tick_count != 32'hFFFF_FFFF)
				tick_count = tick_count + 1;
			if (elapsed >= {5'b0, interval}) begin
				r.taken = 1'b1;
				if (elapsed != 0) begin
					wide = 64'(tick_count);
					wide = wide * interval;
					wide = wide / elapsed;
					rate = sat32(wide);
				end else begin
					rate = '0;
				end
				per_mhz = '0;
				if (khz != 0) begin
					wide = 64'(rate);
					wide = wide * RATE_SCALE;
					per_mhz = 64'(sat32(wide / khz));
				end
				if (per_mhz > peak)
					peak = per_mhz[31:0];
				if (peak != 0) begin
					headroom = (per_mhz * PERMILLE_FULL) / peak;
					load = (headroom >= PERMILLE_FULL) ? '0 : PERMILLE_FULL - headroom[LOAD_W-1:0];
				end
				tick_count = '0;
				last_stamp = now;
			end
			r.ips  = rate;
			r.load = load;
			expected.push_back(r);
		endfunction

		function void check_result(input logic [31:0] ips, input logic [LOAD_W-1:0] ld,
				input logic taken);
			load_result_t e;
			if (expected.size() == 0) begin
				$error("result transaction with no expected result waiting");
				errors++;
				return;
			end
			e = expected.pop_front();
			if (ips !== e.ips) begin
				$error("iterations_per_sec: expected %0d, actual %0d", e.ips, ips);
				errors++;
			end
			if (ld !== e.load) begin
				$error("load_permille: expected %0d, actual %0d", e.load, ld);
				errors++;
			end
			if (taken !== e.taken) begin
				$error("sample_taken: expected %0d, actual %0d", e.taken, taken);
				errors++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [31:0]           now_us = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [31:0]           iterations_per_sec;
	logic [LOAD_W-1:0]     load_permille;
	logic                  sample_taken;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [INTERVAL_W-1:0] cfg_data = '0;

	load_scoreboard sb;
	int unsigned    in_idle_max = 5;
	int unsigned    out_idle_max = 5;
	bit             long_hold = 1'b0;
	logic [31:0]    stamp_now = '0;

	loop_load_monitor_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_us(now_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.iterations_per_sec(iterations_per_sec),
		.load_permille(load_permille),
		.sample_taken(sample_taken),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_tick(input logic [31:0] stamp);
		int unsigned gap;
		gap = $urandom_range(0, in_idle_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		now_us <= stamp;
		do @(posedge clk); while (in_stall);
		sb.note_tick(stamp);
		stamp_now = stamp;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [INTERVAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_config(input logic [INTERVAL_W-1:0] interval, input logic [KHZ_W-1:0] khz);
		logic [INTERVAL_W-1:0] khz_word;
		khz_word = INTERVAL_W'($urandom);
		khz_word[KHZ_W-1:0] = khz;
		settle();
		cfg_write(REG_INTERVAL, interval);
		cfg_write(REG_KHZ, khz_word);
	endtask

	task automatic run_random(input logic [INTERVAL_W-1:0] interval, input logic [KHZ_W-1:0] khz,
			input bit with_hold);
		logic [31:0] stamp;
		int unsigned step_max;
		int unsigned pick;
		step_max = 1;
		write_config(interval, khz);
		for (int i = 0; i < 205; i++) begin
			if (i % 64 == 0) begin
				in_idle_max = $urandom_range(0, 1) * 13;
				out_idle_max = $urandom_range(0, 1) * 13;
				step_max = interval / $urandom_range(1, 40) + 1;
			end
			if (with_hold && i == 100) begin
				in_idle_max = 0;
				long_hold = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 8)
				stamp = $urandom;
			else if (pick < 12)
				stamp = sb.last_stamp + interval;
			else if (pick < 15)
				stamp = sb.last_stamp + interval - 1;
			else
				stamp = stamp_now + $urandom_range(0, step_max);
			send_tick(stamp);
		end
	endtask

	initial begin
		int hold;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				hold = 600;
			end else begin
				hold = $urandom_range(0, out_idle_max);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result(iterations_per_sec, load_permille, sample_taken);
			@(negedge clk);
		end
	end

	initial begin
		sb = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero peak keeps the load, and a sample closes across the time wrap.
		send_tick(32'd0);
		send_tick(32'd999_999);
		send_tick(32'd1_000_000);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'd0);
		send_tick(32'd999_999);

		write_config(27'd10, 20'd1);
		send_tick(32'd1_000_005);
		send_tick(32'd1_000_009);
		send_tick(32'd1_000_010);
		send_tick(32'd1_000_011);
		send_tick(32'd1_000_012);
		send_tick(32'd1_000_019);
		send_tick(32'd1_000_039);
		send_tick(32'd1_000_041);
		send_tick(32'd1_000_049);

		write_config(27'd10, 20'd0);
		send_tick(32'd1_000_059);

		write_config(27'd0, 20'd0);
		send_tick(32'd1_000_059);
		send_tick(32'd1_000_060);

		run_random(27'd100, 20'd1, 1'b0);
		run_random(27'd0, 20'd0, 1'b0);
		run_random(27'h7FF_FFFF, 20'hF_FFFF, 1'b0);
		run_random(27'd1, 20'd3, 1'b1);
		settle();
		cfg_write(REG_SPARE_LO, INTERVAL_W'($urandom));
		cfg_write(REG_SPARE_HI, INTERVAL_W'($urandom));
		run_random(27'd1000, 20'd20, 1'b0);
		run_random(INTERVAL_W'($urandom_range(1, 5000)), KHZ_W'($urandom_range(1, 200)), 1'b0);
		run_random(27'd50, 20'd1_000_000, 1'b0);
		run_random(INTERVAL_W'($urandom), KHZ_W'($urandom), 1'b0);
		run_random(INTERVAL_RESET, KHZ_RESET, 1'b0);
		settle();

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
